// File: src/crq_pkg.sv
// ----------------------------------------------------------------------------
// crq_pkg
// Shared types and constants of the crop-window RGB565 pixel quantiser.
// ----------------------------------------------------------------------------
package crq_pkg;

  localparam int PIX_W      = 16;
  localparam int VALUE_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_QUANT_MODE  = 3'd0;
  localparam cfg_idx_t REG_CROP_LEFT   = 3'd1;
  localparam cfg_idx_t REG_CROP_TOP    = 3'd2;
  localparam cfg_idx_t REG_CROP_WIDTH  = 3'd3;
  localparam cfg_idx_t REG_CROP_HEIGHT = 3'd4;
  localparam cfg_idx_t REG_LINE_WIDTH  = 3'd5;

  typedef logic [1:0] qmode_t;

  localparam qmode_t QM_OFFSET   = 2'd0;
  localparam qmode_t QM_SCALE    = 2'd1;
  localparam qmode_t QM_FRACTION = 2'd2;

  localparam logic [7:0] RED_MASK   = 8'hF8;
  localparam logic [7:0] GREEN_MASK = 8'hFC;
  localparam logic [7:0] BLUE_MASK  = 8'hF8;

  localparam int QUANT_OFFSET = 128;
  localparam int SCALE_MAX    = 127;
  localparam int ROUND_BIAS   = 127;
  localparam int DIVISOR      = 255;
  localparam int SCALE_SHIFT  = 7;

  typedef struct packed {
    qmode_t      quant_mode;
    logic [11:0] crop_left;
    logic [11:0] crop_top;
    logic [12:0] crop_width;
    logic [12:0] crop_height;
    logic [12:0] line_width;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    quant_mode:  QM_OFFSET,
    crop_left:   12'd48,
    crop_top:    12'd8,
    crop_width:  13'd224,
    crop_height: 13'd224,
    line_width:  13'd320
  };

  typedef struct packed {
    logic in_crop;
    logic last;
  } win_t;

endpackage

// File: src/crq_cfg.sv
// ----------------------------------------------------------------------------
// crq_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module crq_cfg import crq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_QUANT_MODE:  cfg_nxt.quant_mode  = cfg_wdata[1:0];
        REG_CROP_LEFT:   cfg_nxt.crop_left   = cfg_wdata[11:0];
        REG_CROP_TOP:    cfg_nxt.crop_top    = cfg_wdata[11:0];
        REG_CROP_WIDTH:  cfg_nxt.crop_width  = cfg_wdata[12:0];
        REG_CROP_HEIGHT: cfg_nxt.crop_height = cfg_wdata[12:0];
        REG_LINE_WIDTH:  cfg_nxt.line_width  = cfg_wdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/crq_window.sv
// ----------------------------------------------------------------------------
// crq_window
// Raster position counters and crop window test for each accepted request.
// ----------------------------------------------------------------------------
module crq_window import crq_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  logic frame_start,
  input  cfg_t cfg,
  output win_t win
);

  localparam int CMP_W = ((COORD_BITS > 14) ? COORD_BITS : 14) + 1;

  logic [COORD_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [COORD_BITS-1:0] col, row;
  logic [CMP_W-1:0]      col_e, row_e, left_e, top_e, hend_e, vend_e, next_e;
  logic                  wrap;

  always_comb begin
    col    = frame_start ? '0 : col_r;
    row    = frame_start ? '0 : row_r;
    col_e  = CMP_W'(col);
    row_e  = CMP_W'(row);
    left_e = CMP_W'(cfg.crop_left);
    top_e  = CMP_W'(cfg.crop_top);
    hend_e = left_e + CMP_W'(cfg.crop_width);
    vend_e = top_e + CMP_W'(cfg.crop_height);
    next_e = col_e + CMP_W'(1);
    wrap   = (next_e >= CMP_W'(cfg.line_width)) || (&col);

    win.in_crop = (col_e >= left_e) && (col_e < hend_e) &&
                  (row_e >= top_e) && (row_e < vend_e);
    win.last    = (next_e == hend_e) && ((row_e + CMP_W'(1)) == vend_e);

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (wrap) begin
        col_nxt = '0;
        row_nxt = row + COORD_BITS'(1);
      end else begin
        col_nxt = col + COORD_BITS'(1);
        row_nxt = row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // A frame start with a line of two or more pixels leaves the position at
  // the second column of the first row.
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_start && (cfg.line_width > 13'd1) |=> (col_r == COORD_BITS'(1)) &&
    (row_r == '0))
    else $error("position wrong after frame start");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(col_r) && $stable(row_r))
    else $error("position moved without a request");

endmodule

// File: src/crq_quant.sv
// ----------------------------------------------------------------------------
// crq_quant
// Quantiser for one 8-bit channel; division by 255 is done as a multiply by
// a reciprocal constant followed by a shift.
// ----------------------------------------------------------------------------
module crq_quant import crq_pkg::*; #(
  parameter int FRACTION_BITS = 15
) (
  input  logic [7:0]                pix,
  input  qmode_t                    mode,
  output logic signed [VALUE_W-1:0] value
);

  localparam int XW = FRACTION_BITS + 9;
  localparam int SH = XW + 8;
  localparam int RW = XW + 1;
  localparam int QW = XW - 7;
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << SH) / 64'd255) + 64'd1);

  logic [XW-1:0]    dividend;
  logic [XW+RW-1:0] prod;
  logic [QW-1:0]    quot;
  logic [QW-1:0]    clamped;

  always_comb begin
    if (mode == QM_FRACTION) begin
      dividend = (XW'(pix) << FRACTION_BITS) + XW'(ROUND_BIAS);
    end else begin
      dividend = (XW'(pix) << SCALE_SHIFT) + XW'(ROUND_BIAS);
    end
    prod    = {{RW{1'b0}}, dividend} * {{XW{1'b0}}, RECIP};
    quot    = prod[XW+RW-1:SH];
    clamped = (quot > QW'(SCALE_MAX)) ? QW'(SCALE_MAX) : quot;

    case (mode)
      QM_OFFSET:   value = $signed(VALUE_W'(pix) - VALUE_W'(QUANT_OFFSET));
      QM_SCALE:    value = $signed(VALUE_W'(clamped));
      QM_FRACTION: value = $signed(VALUE_W'(quot));
      default:     value = '0;
    endcase
  end

endmodule

// File: src/camera_crop_rgb565_quantizer.sv
// ----------------------------------------------------------------------------
// camera_crop_rgb565_quantizer
// Accepted in-window pixels pass a first register, then the result register.
// One pixel per cycle unless the result side stalls; the window test and
// the divide-by-255 multiply each sit between a pair of registers.
// Reset: position counters go to zero and registers take their defaults.
// ----------------------------------------------------------------------------
module camera_crop_rgb565_quantizer import crq_pkg::*; #(
  parameter int COORD_BITS    = 12,
  parameter int FRACTION_BITS = 15
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [PIX_W-1:0]          in_pixel_word,
  input  logic                      in_frame_start,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_red_value,
  output logic signed [VALUE_W-1:0] out_green_value,
  output logic signed [VALUE_W-1:0] out_blue_value,
  output logic                      out_last_of_crop,
  input  logic                      cfg_wr_en,
  input  cfg_idx_t                  cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

  cfg_t cfg;
  win_t win;
  logic accept;
  logic out_adv;

  logic                      s1_v_r, s1_v_nxt;
  logic [PIX_W-1:0]          s1_pix_r;
  logic                      s1_last_r;
  logic                      out_v_r, out_v_nxt;
  logic signed [VALUE_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic                      out_last_r;
  logic signed [VALUE_W-1:0] red_q, green_q, blue_q;
  logic [7:0]                red_p, green_p, blue_p;

  crq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  crq_window #(.COORD_BITS(COORD_BITS)) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_start (in_frame_start),
    .cfg         (cfg),
    .win         (win)
  );

  assign out_adv  = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || out_adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_ready) begin
      s1_v_nxt = accept && win.in_crop;
    end
    out_v_nxt = out_v_r;
    if (out_adv) begin
      out_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_pix_r  <= in_pixel_word;
      s1_last_r <= win.last;
    end
    if (out_adv) begin
      out_red_r   <= red_q;
      out_green_r <= green_q;
      out_blue_r  <= blue_q;
      out_last_r  <= s1_last_r;
    end
  end

  assign red_p   = s1_pix_r[15:8] & RED_MASK;
  assign green_p = s1_pix_r[10:3] & GREEN_MASK;
  assign blue_p  = {s1_pix_r[4:0], 3'b000} & BLUE_MASK;

  crq_quant #(.FRACTION_BITS(FRACTION_BITS)) u_quant_red (
    .pix   (red_p),
    .mode  (cfg.quant_mode),
    .value (red_q)
  );

  crq_quant #(.FRACTION_BITS(FRACTION_BITS)) u_quant_green (
    .pix   (green_p),
    .mode  (cfg.quant_mode),
    .value (green_q)
  );

  crq_quant #(.FRACTION_BITS(FRACTION_BITS)) u_quant_blue (
    .pix   (blue_p),
    .mode  (cfg.quant_mode),
    .value (blue_q)
  );

  assign out_valid        = out_v_r;
  assign out_red_value    = out_red_r;
  assign out_green_value  = out_green_r;
  assign out_blue_value   = out_blue_r;
  assign out_last_of_crop = out_last_r;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !s1_v_r)
    else $error("pipeline not empty after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ready)
    else $error("input stalled while the result register is empty");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_adv |=> out_v_r)
    else $error("pending pixel lost on its way to the result register");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the crop-window RGB565 quantiser. Pixel requests are
// sent with random gaps while the result side stalls at random. Every accepted
// pixel is placed in the window and quantised by an untimed copy of the
// arithmetic. Each result request is then compared, in order, with the pixel
// that is due. The crop window, the line width and the quantisation mode are
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import crq_pkg::*;

  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS     = 15;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE        = 4;
  localparam int RANDOM_PIXELS = 360;
  localparam qmode_t QM_UNUSED = 2'd3;

  typedef struct {
    logic signed [VALUE_W-1:0] red;
    logic signed [VALUE_W-1:0] green;
    logic signed [VALUE_W-1:0] blue;
    logic                      last;
  } crop_pixel_t;

  class cropped_pixels;
    cfg_t                  regs;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    crop_pixel_t           awaited[$];
    int                    errors;

    function new();
      regs   = CFG_RESET;
      column = '0;
      row    = '0;
      errors = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_QUANT_MODE:  regs.quant_mode  = data[1:0];
        REG_CROP_LEFT:   regs.crop_left   = data[11:0];
        REG_CROP_TOP:    regs.crop_top    = data[11:0];
        REG_CROP_WIDTH:  regs.crop_width  = data;
        REG_CROP_HEIGHT: regs.crop_height = data;
        REG_LINE_WIDTH:  regs.line_width  = data;
        default: ;
      endcase
    endfunction

    function logic signed [VALUE_W-1:0] quantize(logic [7:0] p);
      int unsigned level;
      int          v;
      level = p;
      case (regs.quant_mode)
        QM_OFFSET: v = int'(level) - QUANT_OFFSET;
        QM_SCALE: begin
          level = ((level << SCALE_SHIFT) + ROUND_BIAS) / DIVISOR;
          v = (level > SCALE_MAX) ? SCALE_MAX : int'(level);
        end
        QM_FRACTION: v = int'(((level << FRAC_BITS) + ROUND_BIAS) / DIVISOR);
        default: v = 0;
      endcase
      return v[VALUE_W-1:0];
    endfunction

    function void take_pixel(logic [PIX_W-1:0] word, logic start);
      int unsigned col_now;
      int unsigned row_now;
      int unsigned col_end;
      int unsigned row_end;
      crop_pixel_t px;
      if (start) begin
        column = '0;
        row    = '0;
      end
      col_now = column;
      row_now = row;
      col_end = regs.crop_left + regs.crop_width;
      row_end = regs.crop_top + regs.crop_height;
      if (col_now >= regs.crop_left && col_now < col_end &&
          row_now >= regs.crop_top && row_now < row_end) begin
        px.red   = quantize(word[15:8] & RED_MASK);
        px.green = quantize(word[10:3] & GREEN_MASK);
        px.blue  = quantize({word[4:0], 3'b000} & BLUE_MASK);
        px.last  = (col_now + 1 == col_end) && (row_now + 1 == row_end);
        awaited.push_back(px);
      end
      if (col_now + 1 >= regs.line_width || col_now + 1 >= (1 << COORD_BITS)) begin
        column = '0;
        row    = row + 1'b1;
      end else begin
        column = column + 1'b1;
      end
    endfunction

    function void match_output(logic signed [VALUE_W-1:0] red,
                               logic signed [VALUE_W-1:0] green,
                               logic signed [VALUE_W-1:0] blue,
                               logic last);
      crop_pixel_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Result request with no pixel due: r=%0d g=%0d b=%0d last=%0b",
                   red, green, blue, last);
        return;
      end
      want = awaited.pop_front();
      if (red !== want.red || green !== want.green || blue !== want.blue ||
          last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"Pixel mismatch: expected r=%0d g=%0d b=%0d last=%0b, ",
                    "got r=%0d g=%0d b=%0d last=%0b"},
                   want.red, want.green, want.blue, want.last, red, green, blue, last);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [PIX_W-1:0]          in_pixel_word;
  logic                      in_frame_start;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VALUE_W-1:0] out_red_value;
  logic signed [VALUE_W-1:0] out_green_value;
  logic signed [VALUE_W-1:0] out_blue_value;
  logic                      out_last_of_crop;
  logic                      cfg_wr_en;
  cfg_idx_t                  cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;

  cropped_pixels book = new();
  bit            steady_phase = 1'b0;
  int            cycle_count = 0;

  camera_crop_rgb565_quantizer #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRAC_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_word    (in_pixel_word),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red_value    (out_red_value),
    .out_green_value  (out_green_value),
    .out_blue_value   (out_blue_value),
    .out_last_of_crop (out_last_of_crop),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.match_output(out_red_value, out_green_value, out_blue_value, out_last_of_crop);
  end

  function automatic int draw_gap();
    return steady_phase ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic qmode_t pick_mode();
    case ($urandom_range(0, 7))
      0:       return QM_UNUSED;
      1, 2:    return QM_SCALE;
      3, 4:    return QM_FRACTION;
      default: return QM_OFFSET;
    endcase
  endfunction

  function automatic int pick_extent(input int top_value);
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return 4096;
      default: return $urandom_range(1, top_value);
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] word, input logic start);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_word  <= word;
    in_frame_start <= start;
    do @(posedge clk); while (!in_ready);
    book.take_pixel(word, start);
  endtask

  task automatic send_run(input int count, input bit restart, input bit scatter);
    logic start;
    for (int i = 0; i < count; i++) begin
      if (i == 0)
        start = restart;
      else
        start = scatter && ($urandom_range(0, 24) == 0);
      send_pixel(16'($urandom), start);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.awaited.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_register(input cfg_idx_t idx, input int unsigned value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    book.set_register(idx, value[CFG_DATA_W-1:0]);
  endtask

  task automatic program_window(input qmode_t mode, input int left, input int top,
                                input int width, input int height, input int line);
    drain_results();
    put_register(REG_QUANT_MODE, mode);
    put_register(REG_CROP_LEFT, left);
    put_register(REG_CROP_TOP, top);
    put_register(REG_CROP_WIDTH, width);
    put_register(REG_CROP_HEIGHT, height);
    put_register(REG_LINE_WIDTH, line);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int random_sent;
    int count;
    int line;
    int left;
    int top;
    int width;
    int height;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pixel_word  <= '0;
    in_frame_start <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= REG_QUANT_MODE;
    cfg_wdata      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_window(QM_OFFSET, 0, 0, 3, 2, 4);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'h07E0, 1'b0);
    send_pixel(16'h001F, 1'b0);
    send_pixel(16'hA5A5, 1'b0);
    send_pixel(16'h5A5A, 1'b0);
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'h7BEF, 1'b1);

    program_window(QM_SCALE, 0, 0, 3, 2, 4);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h8410, 1'b0);
    send_pixel(16'h0841, 1'b0);

    program_window(QM_FRACTION, 0, 0, 3, 2, 4);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h1082, 1'b0);

    program_window(QM_UNUSED, 0, 0, 3, 2, 4);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h1234, 1'b0);

    program_window(QM_OFFSET, 0, 0, 0, 4, 4);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h8000, 1'b0);

    // With a zero line width the column stays at zero and the row moves on
    // every pixel, so only two pixels of this run fall in the window.
    steady_phase = 1'b1;
    program_window(pick_mode(), 0, 20, 1, 2, 0);
    send_run(40, 1'b1, 1'b0);

    // The line is wider than the column counter can count and the window
    // starts at its last column, so none of these pixels is in the window.
    steady_phase = 1'b0;
    program_window(pick_mode(), 4095, 0, 4096, 1, 8191);
    send_run(40, 1'b1, 1'b0);

    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      line   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      left   = $urandom_range(0, 6);
      top    = $urandom_range(0, 4);
      width  = pick_extent(8);
      height = pick_extent(5);
      program_window(pick_mode(), left, top, width, height, line);
      steady_phase = ($urandom_range(0, 3) == 0);
      count = $urandom_range(20, 60);
      send_run(count, $urandom_range(0, 4) != 0, 1'b1);
      random_sent += count;
    end

    steady_phase = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.awaited.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

endmodule
